// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define ILS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clock edge, reset included
`define ILS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ilst_pkg.sv =====
// ----------------------------------------------------------------------------
// ilst_pkg
// shared types and constants of the indexed list store
// ----------------------------------------------------------------------------
package ilst_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 8;
    localparam int MODE_W        = 3;
    localparam int LEN_W         = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ       = 3'd0,
        MODE_INS_HEAD   = 3'd1,
        MODE_INS_TAIL   = 3'd2,
        MODE_INS_INDEX  = 3'd3,
        MODE_DELETE     = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // shift command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// ordered list of signed 32-bit values held in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_mode, i_position, i_item_value
//  result    out        o_valid / i_ready    o_read_value, o_status, o_length
//
//  one request per cycle while the result channel is not stalled; its result is
//  registered and shows in the cycle after the transfer; every cell shifts in the same cycle on insert and delete
//  reset clears the entry count and the result valid flag; cell contents stay
//  undefined until written and are never read before that
//  a stalled result holds; a new request is taken in the same cycle that
//  the waiting result is taken
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int DEPTH = ilst_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ilst_pkg::MODE_W-1:0] i_mode,
    input  logic signed [ilst_pkg::POS_W-1:0]  i_position,
    input  logic signed [ilst_pkg::DATA_W-1:0] i_item_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [ilst_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                  o_status,
    output logic [ilst_pkg::LEN_W-1:0]  o_length
);
    import ilst_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    // compare width covers both the count and a non-negative position
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control and result registers
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_read_value;
    t_status           r_status;
    logic [LEN_W-1:0]  r_length;

    logic [CNT_W-1:0]  n_count;
    logic [DATA_W-1:0] n_read_value;
    t_status           n_status;

    logic              take;
    logic              pos_neg;
    logic [CMP_W-1:0]  pos_u;
    logic [CMP_W-1:0]  cnt_x;
    logic              valid_idx;
    logic              full;
    logic [IDX_W-1:0]  shift_pos;
    t_cell_ctl         cell_ctl;

    logic [DATA_W-1:0] w_data [DEPTH];

    // a new request enters whenever the result register is free or draining
    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;

    // positions are compared in a width that holds both operands
    assign pos_neg   = i_position[POS_W-1];
    assign pos_u     = pos_neg ? '0 : CMP_W'(unsigned'(i_position));
    assign cnt_x     = CMP_W'(r_count);
    assign valid_idx = !pos_neg && (pos_u < cnt_x);
    assign full      = (r_count == FULL_CNT);

    // request decode
    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ST_DONE;
        shift_pos    = '0;
        cell_ctl     = '{ins: 1'b0, del: 1'b0, value: i_item_value};
        unique case (i_mode)
            MODE_READ: begin
                if (valid_idx) begin
                    n_read_value = w_data[pos_u[IDX_W-1:0]];
                end else begin
                    n_status = ST_RANGE;
                end
            end
            MODE_INS_HEAD, MODE_INS_TAIL: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    // head goes in at zero, tail at the current count
                    shift_pos    = (i_mode == MODE_INS_HEAD) ? '0 : r_count[IDX_W-1:0];
                    cell_ctl.ins = take;
                    n_count      = r_count + 1'b1;
                end
            end
            MODE_INS_INDEX: begin
                // a negative position already reads as zero in pos_u
                if (pos_u > cnt_x) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    shift_pos    = pos_u[IDX_W-1:0];
                    cell_ctl.ins = take;
                    n_count      = r_count + 1'b1;
                end
            end
            MODE_DELETE: begin
                if (valid_idx) begin
                    shift_pos    = pos_u[IDX_W-1:0];
                    cell_ctl.del = take;
                    n_count      = r_count - 1'b1;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                // unused mode codes change nothing
                n_status = ST_RANGE;
            end
        endcase
    end

    // row of cells, each fed by its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_lo
            assign w_prev = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_hi
            assign w_next = w_data[g+1];
        end
        ilst_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (cell_ctl),
            .i_pos  (shift_pos),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g])
        );
    end

    // count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each request transfer
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_length     <= LEN_W'(n_count);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_length     = r_length;

endmodule

// ===== rtl/core/ilst_cell.sv =====
// ----------------------------------------------------------------------------
// ilst_cell
// one list slot; shifts up on insert, down on delete
// ----------------------------------------------------------------------------
module ilst_cell #(
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  logic                       i_clk,
    input  ilst_pkg::t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0]           i_pos,
    input  logic [ilst_pkg::DATA_W-1:0] i_prev,
    input  logic [ilst_pkg::DATA_W-1:0] i_next,
    output logic [ilst_pkg::DATA_W-1:0] o_data
);
    import ilst_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_data = i_prev;
            end else if (MY_IDX == i_pos) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/core/ilst_checker.sv =====
// ----------------------------------------------------------------------------
// ilst_checker
// port-level checks of the indexed list store
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ilst_checker #(
    parameter int DEPTH = ilst_pkg::DEPTH_DEFAULT
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [ilst_pkg::DATA_W-1:0] o_read_value,
    input logic [1:0]                  o_status,
    input logic [ilst_pkg::LEN_W-1:0]  o_length
);
    import ilst_pkg::*;

    localparam logic LEN_WRAPS = (DEPTH >= (1 << LEN_W));

    // no result may be pending right after reset
    `ILS_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

    // a waiting result holds its payload
    `ILS_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_read_value) && $stable(o_status) && $stable(o_length), "stalled result changed")

    // failed requests return zero data
    `ILS_ASSERT(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_DONE |-> o_read_value == '0, "error result carries data")

    // reported length never exceeds the depth, unless the depth does not fit in the length field
    `ILS_ASSERT(a_len_bound, i_clk, i_rst_n, o_valid |-> LEN_WRAPS || (o_length <= LEN_W'(DEPTH)), "length beyond depth")

    // an empty result register always takes a request
    `ILS_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "not ready while result empty")

endmodule

bind indexed_list_store ilst_checker #(.DEPTH(DEPTH)) u_ilst_checker (.*);
